>>> src/bed_pkg.sv
// Package for the backslash escape decoder: parse modes, character codes
// and the escape and hex digit lookup functions. No dependencies.
package bed_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCT    = 2'd2,
    MODE_HEX    = 2'd3
  } parse_mode_e;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_ESC    = 8'h1B;

  localparam logic [1:0] OCT_LIMIT = 2'd3;
  localparam logic [1:0] HEX_LIMIT = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t esc_lookup(input logic [7:0] b);
    esc_t r;
    r.hit  = 1'b1;
    r.code = 8'h00;
    case (b)
      8'h6E:       r.code = 8'h0A;
      8'h74:       r.code = 8'h09;
      8'h72:       r.code = 8'h0D;
      8'h61:       r.code = 8'h07;
      8'h62:       r.code = 8'h08;
      8'h66:       r.code = 8'h0C;
      8'h76:       r.code = 8'h0B;
      CHAR_BSLASH: r.code = CHAR_BSLASH;
      8'h65:       r.code = CHAR_ESC;
      default:     r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t hex_digit(input logic [7:0] b);
    digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.val = 4'(b - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> src/backslash_escape_decoder_core.sv
// With the result queue empty, the first result of an input transaction passes the input
// register and the result queue before it is offered. Throughput: one input transaction
// per cycle while each yields at most one result; one result per cycle leaves the output
// while m_axis_tready is high, and input stalls while the queue holds over two entries.
// Reset: rst_ni clears the input stage, the result queue, the parse state and escape_enable.
// Top level of the backslash escape decoder; depends on bed_pkg.
module backslash_escape_decoder_core
  import bed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // escape_enable
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] text_byte
  input  logic       s_axis_tlast,    // string_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] decoded_byte
  output logic       m_axis_tlast     // run_last
);

  logic              enable_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;
  parse_mode_e       mode_q, mode_d;
  logic [7:0]        val_q, val_d;
  logic [1:0]        cnt_q, cnt_d;

  result_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  logic              fire;
  logic              push_ok;
  logic              pop;
  logic [1:0]        n_res;
  logic [7:0]        res0, res1;
  esc_t              esc;
  digit_t            hdig;
  logic              odig_ok;
  logic              dig_ok;
  logic [7:0]        val_n;
  logic [1:0]        cnt_n;
  logic              is_oct;

  assign push_ok       = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign fire          = in_valid_q && push_ok;
  assign s_axis_tready = !in_valid_q || fire;
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = queue_q[rd_ptr_q].data;
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

  assign esc     = esc_lookup(in_byte_q);
  assign hdig    = hex_digit(in_byte_q);
  assign odig_ok = in_byte_q[7:3] == 5'b00110;
  assign is_oct  = mode_q == MODE_OCT;
  assign dig_ok  = is_oct ? odig_ok : hdig.ok;
  assign val_n   = is_oct ? {val_q[4:0], in_byte_q[2:0]} : {val_q[3:0], hdig.val};
  assign cnt_n   = cnt_q + 2'd1;

  always_comb begin
    n_res  = 2'd0;
    res0   = in_byte_q;
    res1   = in_byte_q;
    mode_d = mode_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    if (!enable_q) begin
      n_res  = 2'd1;
      mode_d = MODE_PLAIN;
      val_d  = 8'd0;
      cnt_d  = 2'd0;
    end else begin
      case (mode_q)
        MODE_PLAIN: begin
          if (in_byte_q == CHAR_BSLASH) begin
            mode_d = MODE_BSLASH;
          end else begin
            n_res = 2'd1;
          end
        end
        MODE_BSLASH: begin
          if (esc.hit) begin
            n_res  = 2'd1;
            res0   = esc.code;
            mode_d = MODE_PLAIN;
          end else if (odig_ok) begin
            mode_d = MODE_OCT;
            val_d  = {5'd0, in_byte_q[2:0]};
            cnt_d  = 2'd1;
          end else if (in_byte_q == CHAR_X) begin
            mode_d = MODE_HEX;
            val_d  = 8'd0;
            cnt_d  = 2'd0;
          end else begin
            n_res  = 2'd2;
            res0   = CHAR_BSLASH;
            mode_d = MODE_PLAIN;
          end
        end
        MODE_OCT, MODE_HEX: begin
          if (dig_ok) begin
            if (cnt_n >= (is_oct ? OCT_LIMIT : HEX_LIMIT)) begin
              n_res  = 2'd1;
              res0   = val_n;
              mode_d = MODE_PLAIN;
              val_d  = 8'd0;
              cnt_d  = 2'd0;
            end else begin
              val_d = val_n;
              cnt_d = cnt_n;
            end
          end else begin
            res0  = val_q;
            val_d = 8'd0;
            cnt_d = 2'd0;
            if (in_byte_q == CHAR_BSLASH) begin
              n_res  = 2'd1;
              mode_d = MODE_BSLASH;
            end else begin
              n_res  = 2'd2;
              mode_d = MODE_PLAIN;
            end
          end
        end
        default: begin
          mode_d = MODE_PLAIN;
        end
      endcase
      if (in_end_q) begin
        if (mode_d == MODE_OCT || mode_d == MODE_HEX) begin
          n_res = 2'd1;
          res0  = val_d;
        end
        mode_d = MODE_PLAIN;
        val_d  = 8'd0;
        cnt_d  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      in_valid_q <= 1'b0;
      mode_q     <= MODE_PLAIN;
      val_q      <= 8'd0;
      cnt_q      <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire) begin
        mode_q <= mode_d;
        val_q  <= val_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + (fire ? QCNT_W'(n_res) : QCNT_W'(0))
                         - (pop ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= '{last: n_res == 2'd1, data: res0};
      if (n_res == 2'd2) begin
        queue_q[wr_ptr_q + QPTR_W'(1)] <= '{last: 1'b1, data: res1};
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_end_q) |=> (mode_q == MODE_PLAIN && cnt_q == 2'd0))
    else $error("parse state not cleared at string end");

  a_bypass_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !enable_q) |=> mode_q == MODE_PLAIN)
    else $error("parse state not plain with decoding off");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> count_q <= $past(count_q) + QCNT_W'(2))
    else $error("result queue grew by more than two");
`endif

endmodule
